[rtl/lce_pkg.sv]
package lce_pkg;

  localparam int CNT_W   = 10;  // tick countdown width
  localparam int PHASE_W = 3;
  localparam int CH_W    = 8;   // one color channel
  localparam int RGB_W   = 3 * CH_W;
  localparam int SPEED_W = 7;
  localparam int MODE_W  = 3;

  // effect_mode codes
  localparam logic [MODE_W-1:0] MODE_CONTINUOUS = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FLASH      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STROBE     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FADE       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SMOOTH     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_EFFECT_MODE   = 2'd0;
  localparam logic [1:0] REG_BASE_COLOR    = 2'd1;
  localparam logic [1:0] REG_SPEED_SETTING = 2'd2;
  localparam logic [1:0] REG_POWER_LEVEL   = 2'd3;

  localparam logic [RGB_W-1:0] COLOR_RED   = 24'hFF0000;
  localparam logic [RGB_W-1:0] COLOR_GREEN = 24'h00FF00;
  localparam logic [RGB_W-1:0] COLOR_BLUE  = 24'h0000FF;
  localparam logic [RGB_W-1:0] COLOR_BLACK = 24'h000000;
  localparam logic [CH_W-1:0]  CH_MAX      = 8'hFF;

  localparam logic [3:0] SPEED_STEP_MS = 4'd10;
  // floor(p/50) = (p * 1311) >> 16, exact for p < 1024
  localparam logic [10:0] RECIP_50   = 11'd1311;
  localparam int          RECIP_SHFT = 16;
  localparam int          SMOOTH_SHFT = 3;  // period / 8

  typedef struct packed {
    logic [CNT_W-1:0]   countdown;
    logic [PHASE_W-1:0] phase;
    logic [CH_W-1:0]    fade_level;
    logic               fade_rising;
    logic [CH_W-1:0]    wheel_red;
    logic [CH_W-1:0]    wheel_green;
    logic [CH_W-1:0]    wheel_blue;
  } effect_state_t;

  localparam effect_state_t STATE_RESET = '{
    countdown:   '0,
    phase:       '0,
    fade_level:  '0,
    fade_rising: 1'b0,
    wheel_red:   CH_MAX,
    wheel_green: '0,
    wheel_blue:  '0
  };

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [RGB_W-1:0]   base_color;
    logic [SPEED_W-1:0] speed;
  } effect_cfg_t;

  // exact floor(x/255) for x up to 255*255
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] s;
    s = {1'b0, x} + {{(CH_W+1){1'b0}}, x[2*CH_W-1:CH_W]} + 17'd1;
    return s[2*CH_W-1:CH_W];
  endfunction

endpackage

[rtl/led_color_effect_generator.sv]
// LED color effect generator.
// Input stream (s_*): one request per millisecond tick; s_tdata[0] is restart,
// which puts the effect back to its first step and starts a new step on that tick.
// Output stream (m_*): exactly one request per input request, carrying the
// current frame (red, green, blue, power) and, in m_tuser, frame_valid, which
// is high when a new step began on that tick. Between steps the last frame is
// repeated with frame_valid low.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 mode,
// 1 base color, 2 speed, 3 power); write only while the block is idle.
// The result of an accepted tick is registered and appears in the next cycle.
// Throughput: one tick per cycle; the whole step (period arithmetic, fade
// multiply, wheel update) sits between the state registers and the output
// register. A tick is taken while the output register is empty or being
// drained the same cycle, so a stalled receiver holds back the input side.
// Reset (rst, synchronous): registers cleared to zero, wheel at pure red, held
// frame black, output empty, first tick starts a step at once.
module led_color_effect_generator
  import lce_pkg::*;
#(
  parameter int PERIOD_BASE_MS = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] red_out, [15:8] green_out,
                                 // [23:16] blue_out, [31:24] power_out
  output logic [0:0]  m_tuser,   // [0] frame_valid
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  // configuration registers
  logic [MODE_W-1:0]  effect_mode;
  logic [RGB_W-1:0]   base_color;
  logic [SPEED_W-1:0] speed_setting;
  logic [CH_W-1:0]    power_level;

  effect_state_t    state, cur, step_next;
  effect_cfg_t      cfg;
  logic [RGB_W-1:0] frame;
  logic             take;
  logic             new_step;

  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  // restart overrides the stored state for this tick
  assign cur      = s_tdata[0] ? STATE_RESET : state;
  assign new_step = (cur.countdown == '0);
  assign cfg      = '{mode: effect_mode, base_color: base_color, speed: speed_setting};

  lce_step #(
    .PERIOD_BASE_MS(PERIOD_BASE_MS)
  ) u_step (
    .cfg  (cfg),
    .cur  (cur),
    .nxt  (step_next),
    .frame(frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode   <= MODE_CONTINUOUS;
      base_color    <= '0;
      speed_setting <= '0;
      power_level   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EFFECT_MODE:   effect_mode   <= cfg_wdata[MODE_W-1:0];
        REG_BASE_COLOR:    base_color    <= cfg_wdata[RGB_W-1:0];
        REG_SPEED_SETTING: speed_setting <= cfg_wdata[SPEED_W-1:0];
        REG_POWER_LEVEL:   power_level   <= cfg_wdata[CH_W-1:0];
      endcase
    end
  end

  // effect state, held frame and output request
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= STATE_RESET;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= '0;
    end else begin
      if (take) begin
        m_tvalid <= 1'b1;
        if (new_step) begin
          state   <= step_next;
          // frame repeats until the next step
          m_tdata <= {power_level, frame[7:0], frame[15:8], frame[23:16]};
          m_tuser <= 1'b1;
        end else begin
          // restart always opens a step, so only the countdown moves here
          state.countdown <= state.countdown - CNT_W'(1);
          m_tuser         <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/lce_step.sv]
module lce_step
  import lce_pkg::*;
#(
  parameter int PERIOD_BASE_MS = 1000
) (
  input  effect_cfg_t      cfg,
  input  effect_state_t    cur,
  output effect_state_t    nxt,
  output logic [RGB_W-1:0] frame
);

  localparam logic [CNT_W:0] BASE = (CNT_W + 1)'(PERIOD_BASE_MS);

  logic [CNT_W:0]      cut;
  logic [CNT_W-1:0]    speed_p;
  logic [CNT_W+10:0]   fade_prod;
  logic [CNT_W-1:0]    period;
  logic [2*CH_W-1:0]   pr, pg, pb;
  logic [PHASE_W-1:0]  c;

  always_comb begin
    cut     = (CNT_W + 1)'(cfg.speed) * (CNT_W + 1)'(SPEED_STEP_MS);
    speed_p = (cut >= BASE) ? '0 : CNT_W'(BASE - cut);
    fade_prod = (CNT_W + 11)'(speed_p) * (CNT_W + 11)'(RECIP_50);
    pr = cfg.base_color[23:16] * cur.fade_level;
    pg = cfg.base_color[15:8]  * cur.fade_level;
    pb = cfg.base_color[7:0]   * cur.fade_level;
  end

  always_comb begin
    nxt    = cur;
    frame  = COLOR_BLACK;
    period = CNT_W'(BASE);
    c      = '0;
    unique case (cfg.mode)
      MODE_CONTINUOUS: begin
        frame = cfg.base_color;
      end
      MODE_FLASH: begin
        c = (cur.phase > 3'd2) ? 3'd0 : cur.phase;
        unique case (c)
          3'd0:    frame = COLOR_RED;
          3'd1:    frame = COLOR_GREEN;
          default: frame = COLOR_BLUE;
        endcase
        nxt.phase = (c == 3'd2) ? 3'd0 : c + 3'd1;
        period = speed_p;
      end
      MODE_STROBE: begin
        frame     = (cur.phase == '0) ? cfg.base_color : COLOR_BLACK;
        nxt.phase = (cur.phase == '0) ? 3'd1 : 3'd0;
        period    = speed_p;
      end
      MODE_FADE: begin
        frame = {div255(pr), div255(pg), div255(pb)};
        if (cur.fade_level == CH_MAX) nxt.fade_rising = 1'b0;
        else if (cur.fade_level == '0) nxt.fade_rising = 1'b1;
        nxt.fade_level = nxt.fade_rising ? cur.fade_level + 8'd1 : cur.fade_level - 8'd1;
        period = fade_prod[RECIP_SHFT +: CNT_W];
      end
      MODE_SMOOTH: begin
        frame = {cur.wheel_red, cur.wheel_green, cur.wheel_blue};
        c = (cur.phase > 3'd5) ? 3'd0 : cur.phase;
        nxt.phase = c;
        unique case (c)
          3'd0: begin
            nxt.wheel_green = cur.wheel_green + 8'd1;
            if (nxt.wheel_green == CH_MAX) nxt.phase = 3'd1;
          end
          3'd1: begin
            nxt.wheel_red = cur.wheel_red - 8'd1;
            if (nxt.wheel_red == '0) nxt.phase = 3'd2;
          end
          3'd2: begin
            nxt.wheel_blue = cur.wheel_blue + 8'd1;
            if (nxt.wheel_blue == CH_MAX) nxt.phase = 3'd3;
          end
          3'd3: begin
            nxt.wheel_green = cur.wheel_green - 8'd1;
            if (nxt.wheel_green == '0) nxt.phase = 3'd4;
          end
          3'd4: begin
            nxt.wheel_red = cur.wheel_red + 8'd1;
            if (nxt.wheel_red == CH_MAX) nxt.phase = 3'd5;
          end
          default: begin
            nxt.wheel_blue = cur.wheel_blue - 8'd1;
            if (nxt.wheel_blue == '0) nxt.phase = 3'd0;
          end
        endcase
        period = speed_p >> SMOOTH_SHFT;
      end
      default: begin
        frame = COLOR_BLACK;  // unused modes: black, only the countdown is reloaded
      end
    endcase
    // a zero period lasts one tick
    nxt.countdown = (period == '0) ? '0 : period - CNT_W'(1);
  end

endmodule

[rtl/lce_checker.sv]
module lce_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // stalled output request holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output request changed");

  // no output right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an empty output side never blocks input
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // every accepted tick gives an output request next cycle
  assert property (@(posedge clk) disable iff (rst) s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted tick produced no output request");

  // frame data changes only with a new-frame request
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(m_tdata) |-> m_tvalid && m_tuser[0])
    else $error("frame changed without frame_valid");

endmodule

bind led_color_effect_generator lce_checker u_lce_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
